// ===== hw/rtl/spid_pkg.sv =====
`default_nettype none

package spid_pkg;

    // Field widths of the streaming payload.
    localparam int MEAS_W  = 8;
    localparam int DRIVE_W = 16;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register widths.
    localparam int GAIN_W   = 16;
    localparam int SETPT_W  = 8;
    localparam int ILIM_W   = 8;
    localparam int OLIM_W   = 15;

    // State widths.
    localparam int ERR_W   = 9;
    localparam int INTEG_W = 10;

    // Default number of fractional bits in each gain.
    localparam int GAIN_FRAC_BITS_DEF = 12;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_P_RST = 16'd4096;
    localparam logic [GAIN_W-1:0]  GAIN_I_RST = 16'd0;
    localparam logic [GAIN_W-1:0]  GAIN_D_RST = 16'd41;
    localparam logic [SETPT_W-1:0] SETPT_RST  = 8'd90;
    localparam logic [ILIM_W-1:0]  ILIM_RST   = 8'd18;
    localparam logic [OLIM_W-1:0]  OLIM_RST   = 15'd120;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_SETPOINT       = 3'd3,
        CFG_INTEGRAL_LIMIT = 3'd4,
        CFG_OUTPUT_LIMIT   = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== hw/rtl/steering_pid_step_unit.sv =====
// An accepted measurement request is held in the input register; its drive is then offered
// from the result register. Throughput: one measurement per cycle while m_axis_tready is high,
// as a stalled result register blocks the input register; error, integral, derivative, the three
// gain products, truncation and saturation all sit between the input and result registers.
// Reset (rst_n low, asynchronous): pipeline empty, integral and last error zero,
// configuration registers return to their default gains, setpoint and limits.
`default_nettype none

module steering_pid_step_unit
    import spid_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // Measurement stream.
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [MEAS_W-1:0]     s_axis_tdata,   // [7:0] measurement
    // Drive stream.
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [DRIVE_W-1:0]         m_axis_tdata    // [15:0] drive
);

    // Accumulator width: covers the exact sum of the three products.
    localparam int ACC_W = 30;
    localparam logic signed [ACC_W-1:0] ROUND_BIAS =
        ACC_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // Configuration registers.
    logic [GAIN_W-1:0]  gain_p_reg;
    logic [GAIN_W-1:0]  gain_i_reg;
    logic [GAIN_W-1:0]  gain_d_reg;
    logic [SETPT_W-1:0] setpoint_reg;
    logic [ILIM_W-1:0]  ilim_reg;
    logic [OLIM_W-1:0]  olim_reg;

    // Controller state.
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;

    // Pipeline registers.
    logic               v0_reg;
    logic [MEAS_W-1:0]  meas_reg;
    logic               v1_reg;
    logic [DRIVE_W-1:0] drive_reg;

    // Handshake and stage advance.
    logic ld1;
    logic s_fire;
    logic mv01;

    // Error, integral, derivative and product signals.
    logic signed [ERR_W-1:0]   err;
    logic signed [INTEG_W:0]   iraw;
    logic signed [INTEG_W:0]   ilim_pos;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [INTEG_W-1:0] der;
    logic signed [ACC_W-1:0]   gp_x;
    logic signed [ACC_W-1:0]   gi_x;
    logic signed [ACC_W-1:0]   gd_x;
    logic signed [ACC_W-1:0]   prod_p_next;
    logic signed [ACC_W-1:0]   prod_i_next;
    logic signed [ACC_W-1:0]   prod_d_next;

    // Sum and saturation signals.
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] acc_b;
    logic signed [ACC_W-1:0] quot;
    logic signed [ACC_W-1:0] olim_pos;
    logic signed [ACC_W-1:0] olim_neg;
    logic [DRIVE_W-1:0]      drive_next;

    // A stage loads when it is empty or its content moves on.
    assign ld1           = !v1_reg || m_axis_tready;
    assign s_axis_tready = !v0_reg || ld1;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign mv01          = v0_reg && ld1;

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = v1_reg;
    assign m_axis_tdata  = drive_reg;

    // Configuration register writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= GAIN_P_RST;
            gain_i_reg   <= GAIN_I_RST;
            gain_d_reg   <= GAIN_D_RST;
            setpoint_reg <= SETPT_RST;
            ilim_reg     <= ILIM_RST;
            olim_reg     <= OLIM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:         gain_p_reg   <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_I:         gain_i_reg   <= cfg_data[GAIN_W-1:0];
                CFG_GAIN_D:         gain_d_reg   <= cfg_data[GAIN_W-1:0];
                CFG_SETPOINT:       setpoint_reg <= cfg_data[SETPT_W-1:0];
                CFG_INTEGRAL_LIMIT: ilim_reg     <= cfg_data[ILIM_W-1:0];
                CFG_OUTPUT_LIMIT:   olim_reg     <= cfg_data[OLIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Error, raw integral, derivative and the three gain products.
    always_comb
    begin
        err  = $signed({1'b0, setpoint_reg}) - $signed({1'b0, meas_reg});
        iraw = (INTEG_W+1)'(integ_reg) + (INTEG_W+1)'(err);
        der  = INTEG_W'(err) - INTEG_W'(prev_err_reg);

        ilim_pos = $signed((INTEG_W+1)'(ilim_reg));
        if (iraw > ilim_pos)
        begin
            integ_next = INTEG_W'(ilim_pos);
        end
        else if (iraw < -ilim_pos)
        begin
            integ_next = INTEG_W'(-ilim_pos);
        end
        else
        begin
            integ_next = INTEG_W'(iraw);
        end

        gp_x = $signed(ACC_W'(gain_p_reg));
        gi_x = $signed(ACC_W'(gain_i_reg));
        gd_x = $signed(ACC_W'(gain_d_reg));
        prod_p_next = gp_x * ACC_W'(err);
        prod_i_next = gi_x * ACC_W'(iraw);
        prod_d_next = gd_x * ACC_W'(der);
    end

    // Sum, truncate toward zero and saturate to the output limit.
    always_comb
    begin
        acc      = prod_p_next + prod_i_next + prod_d_next;
        acc_b    = acc[ACC_W-1] ? (acc + ROUND_BIAS) : acc;
        quot     = acc_b >>> GAIN_FRAC_BITS;
        olim_pos = $signed(ACC_W'(olim_reg));
        olim_neg = -olim_pos;
        if (quot > olim_pos)
        begin
            drive_next = DRIVE_W'(olim_pos);
        end
        else if (quot < olim_neg)
        begin
            drive_next = DRIVE_W'(olim_neg);
        end
        else
        begin
            drive_next = DRIVE_W'(quot);
        end
    end

    // Stage valid bits and controller state; the state advances as an item leaves
    // the input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg       <= 1'b0;
            v1_reg       <= 1'b0;
            integ_reg    <= '0;
            prev_err_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                v0_reg <= s_fire;
            end
            if (ld1)
            begin
                v1_reg <= mv01;
            end
            if (mv01)
            begin
                integ_reg    <= integ_next;
                prev_err_reg <= err;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            meas_reg <= s_axis_tdata;
        end
        if (mv01)
        begin
            drive_reg <= drive_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/spid_checker.sv =====
`default_nettype none

module spid_checker
    import spid_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [DRIVE_W-1:0] m_axis_tdata
);

    // A stalled drive request stays offered.
    a_out_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("drive request dropped while stalled");

    // A stalled drive keeps its value.
    a_out_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("drive changed while stalled");

    // With the output side ready, the measurement side is never blocked.
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked although output is ready");

    // An accepted measurement, followed by a ready output side, has its drive offered without a stall.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("drive missing after pipeline latency");

endmodule

bind steering_pid_step_unit spid_checker u_spid_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
